// ===== hw/rtl/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsb_pkg
// Shared types, widths, codes and helpers of the B-spline surface evaluator.
// ----------------------------------------------------------------------------
package bsb_pkg;

	localparam int DEF_MAX_ROWS   = 16;
	localparam int DEF_MAX_COLS   = 16;
	localparam int DEF_MAX_DEGREE = 5;

	// Counts and spans are sized for the largest grid the parameters allow.
	localparam int CNT_W      = 7;
	localparam int DEG_W      = 3;
	localparam int PAR_W      = 17;
	localparam int ONE_Q16    = 65536;
	localparam int XS_W       = 24;
	localparam int BASIS_W    = 31;
	localparam int PROD_W     = BASIS_W + XS_W;
	localparam int FRAC_W     = 30;
	localparam int COORD_W    = 32;
	localparam int MPROD_W    = 64;
	localparam int ACC_W      = 68;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int STAT_W     = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UDEG = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VDEG = 2'd3;

	localparam logic [CFG_DATA_W-1:0] RST_ROWS = 5'd4;
	localparam logic [CFG_DATA_W-1:0] RST_COLS = 5'd4;
	localparam logic [DEG_W-1:0]      RST_UDEG = 3'd3;
	localparam logic [DEG_W-1:0]      RST_VDEG = 3'd3;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FEW   = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	// Request to the basis unit for one direction.
	typedef struct packed {
		logic [CNT_W-1:0] npts;
		logic [DEG_W-1:0] deg;
		logic [PAR_W-1:0] x;
	} bsb_req_t;

	// Spans and degrees handed to the accumulation sequencer.
	typedef struct packed {
		logic [CNT_W-1:0] span_u;
		logic [CNT_W-1:0] span_v;
		logic [DEG_W-1:0] p;
		logic [DEG_W-1:0] q;
	} bsb_mac_ctl_t;

	// Floor of v / 2^30, saturated to a signed 32-bit word.
	function automatic logic [COORD_W-1:0] sat_floor(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] s;
		logic [ACC_W-COORD_W:0] top;
		s = v >>> FRAC_W;
		top = s[ACC_W-1:COORD_W-1];
		if ((&top) || !(|top)) begin
			return s[COORD_W-1:0];
		end else if (s[ACC_W-1]) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

endpackage

// ===== hw/rtl/bspline_surface_point_eval.sv =====
// ----------------------------------------------------------------------------
// bspline_surface_point_eval
// Tensor-product B-spline surface point evaluator in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One item is handled at a time; in_stall stays high until its result word
// has been taken. A load word is answered straight from the idle state, as
// are errors (too few points, parameter above 1.0). An evaluate word runs
// the basis unit for u, then for v, then the sum phase; its length is set by
// the bit-serial divider of the basis recurrence and the single multiplier
// that forms every weighted term in turn.
module bspline_surface_point_eval #(
	parameter int MAX_ROWS   = bsb_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS   = bsb_pkg::DEF_MAX_COLS,
	parameter int MAX_DEGREE = bsb_pkg::DEF_MAX_DEGREE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bsb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bsb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [3:0]                      row_index,
	input  logic [3:0]                      col_index,
	input  logic signed [31:0]              point_x,
	input  logic signed [31:0]              point_y,
	input  logic signed [31:0]              point_z,
	input  logic [16:0]                     u_coord,
	input  logic [16:0]                     v_coord,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [bsb_pkg::STAT_W-1:0]      status,
	output logic signed [31:0]              out_x,
	output logic signed [31:0]              out_y,
	output logic signed [31:0]              out_z
);
	import bsb_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = $clog2(DEPTH);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_BU   = 2'd1;
	localparam logic [1:0] T_BV   = 2'd2;
	localparam logic [1:0] T_MAC  = 2'd3;

	logic [1:0]                       st_q;
	logic [CFG_DATA_W-1:0]            rows_q;
	logic [CFG_DATA_W-1:0]            cols_q;
	logic [DEG_W-1:0]                 udeg_q;
	logic [DEG_W-1:0]                 vdeg_q;
	logic [PAR_W-1:0]                 v_q;
	logic [CNT_W-1:0]                 su_q;
	logic [CNT_W-1:0]                 sv_q;
	logic [MAX_DEGREE:0][BASIS_W-1:0] nu_q;
	logic [MAX_DEGREE:0][BASIS_W-1:0] nv_q;
	logic                             out_valid_q;
	logic [STAT_W-1:0]                status_q;
	logic [COORD_W-1:0]               ox_q;
	logic [COORD_W-1:0]               oy_q;
	logic [COORD_W-1:0]               oz_q;

	logic                             in_accept;
	logic [CNT_W-1:0]                 nr;
	logic [CNT_W-1:0]                 nc;
	logic [DEG_W-1:0]                 p;
	logic [DEG_W-1:0]                 q;
	logic                             too_few;
	logic                             out_of_range;
	logic                             we;
	logic [ADDR_W-1:0]                waddr;
	logic [ADDR_W-1:0]                raddr;
	logic [COORD_W-1:0]               rd_x;
	logic [COORD_W-1:0]               rd_y;
	logic [COORD_W-1:0]               rd_z;
	logic                             bas_start;
	bsb_req_t                         bas_req;
	logic                             bas_done;
	logic [CNT_W-1:0]                 bas_span;
	logic [MAX_DEGREE:0][BASIS_W-1:0] bas_nb;
	logic                             mac_start;
	bsb_mac_ctl_t                     mac_ctl;
	logic                             mac_done;
	logic [COORD_W-1:0]               res_x;
	logic [COORD_W-1:0]               res_y;
	logic [COORD_W-1:0]               res_z;

	always_comb begin
		nr = (CNT_W'(rows_q) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_q);
		nc = (CNT_W'(cols_q) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_q);
		p = (udeg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : udeg_q;
		q = (vdeg_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : vdeg_q;
		too_few = (nr <= CNT_W'(p)) || (nc <= CNT_W'(q));
		out_of_range = (u_coord > PAR_W'(ONE_Q16)) || (v_coord > PAR_W'(ONE_Q16));
		in_stall = (st_q != T_IDLE) || out_valid_q;
		in_accept = in_valid && !in_stall;
		we = in_accept && command == CMD_LOAD &&
			(CNT_W'(row_index) < CNT_W'(MAX_ROWS)) && (CNT_W'(col_index) < CNT_W'(MAX_COLS));
		waddr = ADDR_W'(CNT_W'(row_index) * MAX_COLS + CNT_W'(col_index));
		bas_start = (in_accept && command == CMD_EVAL && !too_few && !out_of_range) ||
			(st_q == T_BU && bas_done);
		if (st_q == T_IDLE) begin
			bas_req = '{npts: nr, deg: p, x: u_coord};
		end else begin
			bas_req = '{npts: nc, deg: q, x: v_q};
		end
		mac_start = (st_q == T_BV) && bas_done;
		mac_ctl = '{span_u: su_q, span_v: bas_span, p: p, q: q};
		if (st_q == T_MAC) begin
			mac_ctl.span_v = sv_q;
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= RST_ROWS;
			cols_q <= RST_COLS;
			udeg_q <= RST_UDEG;
			vdeg_q <= RST_VDEG;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data;
				CFG_COLS: cols_q <= cfg_data;
				CFG_UDEG: udeg_q <= cfg_data[DEG_W-1:0];
				CFG_VDEG: vdeg_q <= cfg_data[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				T_IDLE: begin
					if (in_accept) begin
						if (command == CMD_EVAL && !too_few && !out_of_range) begin
							st_q <= T_BU;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				T_BU: begin
					if (bas_done) begin
						st_q <= T_BV;
					end
				end
				T_BV: begin
					if (bas_done) begin
						st_q <= T_MAC;
					end
				end
				T_MAC: begin
					if (mac_done) begin
						st_q <= T_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			v_q <= v_coord;
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
			if (command == CMD_LOAD) begin
				status_q <= STAT_OK;
			end else if (too_few) begin
				status_q <= STAT_FEW;
			end else if (out_of_range) begin
				status_q <= STAT_RANGE;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if (st_q == T_BU && bas_done) begin
			su_q <= bas_span;
			nu_q <= bas_nb;
		end
		if (st_q == T_BV && bas_done) begin
			sv_q <= bas_span;
			nv_q <= bas_nb;
		end
		if (st_q == T_MAC && mac_done) begin
			ox_q <= res_x;
			oy_q <= res_y;
			oz_q <= res_z;
		end
	end

	bsb_basis #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_basis (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bas_start),
		.req   (bas_req),
		.done  (bas_done),
		.span  (bas_span),
		.nb    (bas_nb)
	);

	bsb_mac #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_COLS  (MAX_COLS),
		.MAX_DEGREE(MAX_DEGREE)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mac_start),
		.ctl   (mac_ctl),
		.nu    (nu_q),
		.nv    (nv_q),
		.raddr (raddr),
		.rd_x  (rd_x),
		.rd_y  (rd_y),
		.rd_z  (rd_z),
		.done  (mac_done),
		.res_x (res_x),
		.res_y (res_y),
		.res_z (res_z)
	);

	bsb_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_grid_x (
		.clk(clk), .we(we), .waddr(waddr), .wdata(point_x), .raddr(raddr), .rdata(rd_x)
	);
	bsb_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_grid_y (
		.clk(clk), .we(we), .waddr(waddr), .wdata(point_y), .raddr(raddr), .rdata(rd_y)
	);
	bsb_ram #(.WIDTH(COORD_W), .DEPTH(DEPTH)) u_grid_z (
		.clk(clk), .we(we), .waddr(waddr), .wdata(point_z), .raddr(raddr), .rdata(rd_z)
	);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_x = ox_q;
	assign out_y = oy_q;
	assign out_z = oz_q;

	a_bas_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		bas_done |-> (st_q == T_BU || st_q == T_BV))
		else $error("basis unit finished outside a basis phase");
	a_mac_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> st_q == T_MAC)
		else $error("accumulator finished outside the sum phase");
	a_few_status: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && command == CMD_EVAL && too_few) |=>
		(out_valid_q && status_q == STAT_FEW && st_q == T_IDLE))
		else $error("too-few-points word not answered at once");
endmodule

// ===== hw/rtl/bsb_ram.sv =====
// ----------------------------------------------------------------------------
// bsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/bsb_basis.sv =====
// ----------------------------------------------------------------------------
// bsb_basis
// Span search and Q0.30 basis recurrence for one direction, using separate
// scaling and recurrence multipliers and a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
module bsb_basis #(
	parameter int MAX_DEGREE = bsb_pkg::DEF_MAX_DEGREE
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  bsb_pkg::bsb_req_t                          req,
	output logic                                       done,
	output logic [bsb_pkg::CNT_W-1:0]                  span,
	output logic [MAX_DEGREE:0][bsb_pkg::BASIS_W-1:0]  nb
);
	import bsb_pkg::*;

	localparam int NB_IDX_W  = $clog2(MAX_DEGREE + 1);
	localparam int DIV_STEPS = BASIS_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);
	localparam int SEG_W     = XS_W - 16;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCALE = 3'd1;
	localparam logic [2:0] S_SPAN  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_LOAD  = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_UPD   = 3'd6;

	logic [2:0]                         st_q;
	logic [PAR_W-1:0]                   x_q;
	logic [DEG_W-1:0]                   deg_q;
	logic [CNT_W-1:0]                   dspan_q;
	logic [XS_W-1:0]                    xs_q;
	logic [CNT_W-1:0]                   span_q;
	logic [DEG_W-1:0]                   j_q;
	logic [DEG_W-1:0]                   r_q;
	logic [BASIS_W-1:0]                 saved_q;
	logic [MAX_DEGREE:0][BASIS_W-1:0]   nb_q;
	logic [PROD_W-1:0]                  prod_q;
	logic [XS_W-1:0]                    den_q;
	logic [XS_W-1:0]                    rem_q;
	logic [BASIS_W-1:0]                 low_q;
	logic [BASIS_W-1:0]                 quo_q;
	logic [DCNT_W-1:0]                  cnt_q;
	logic                               done_q;

	logic [SEG_W-1:0]   seg_raw;
	logic [CNT_W-1:0]   seg;
	logic [BASIS_W-1:0] b;
	logic [XS_W-1:0]    k_right;
	logic [XS_W-1:0]    k_left;
	logic [XS_W-1:0]    rt;
	logic [XS_W-1:0]    lt;
	logic [XS_W:0]      trial;
	logic               ge;
	logic [BASIS_W-1:0] part;

	// Clamped uniform knot i, in units of 2^-16.
	function automatic logic [XS_W-1:0] knot(input logic [CNT_W:0] i,
		input logic [DEG_W-1:0] deg, input logic [CNT_W-1:0] dsp);
		logic signed [CNT_W+1:0] k;
		k = $signed({1'b0, i}) - $signed({{(CNT_W+2-DEG_W){1'b0}}, deg});
		if (k < 0) begin
			k = '0;
		end else if (k > $signed({2'b00, dsp})) begin
			k = $signed({2'b00, dsp});
		end
		return XS_W'({k[CNT_W-1:0], 16'h0000});
	endfunction

	always_comb begin
		seg_raw = xs_q[XS_W-1:16];
		if ({1'b0, seg_raw} >= (SEG_W+1)'(dspan_q)) begin
			seg = dspan_q - 1'b1;
		end else begin
			seg = CNT_W'(seg_raw);
		end
		b = nb_q[r_q[NB_IDX_W-1:0]];
		k_right = knot((CNT_W+1)'(span_q) + (CNT_W+1)'(r_q) + 1'b1, deg_q, dspan_q);
		k_left = knot((CNT_W+1)'(span_q) + 1'b1 + (CNT_W+1)'(r_q) - (CNT_W+1)'(j_q),
			deg_q, dspan_q);
		rt = k_right - xs_q;
		lt = xs_q - k_left;
		trial = {rem_q, low_q[BASIS_W-1]};
		ge = trial >= {1'b0, den_q};
		part = (den_q == '0) ? '0 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						st_q <= S_SCALE;
					end
				end
				S_SCALE: st_q <= S_SPAN;
				S_SPAN: begin
					if (deg_q == '0) begin
						st_q <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= S_MUL;
					end
				end
				S_MUL: st_q <= S_LOAD;
				S_LOAD: st_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (r_q == j_q - 1'b1 && j_q == deg_q) begin
						st_q <= S_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= S_MUL;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (start) begin
					x_q <= req.x;
					deg_q <= req.deg;
					dspan_q <= req.npts - CNT_W'(req.deg);
				end
			end
			S_SCALE: xs_q <= XS_W'(x_q * dspan_q);
			S_SPAN: begin
				span_q <= CNT_W'(deg_q) + seg;
				nb_q[0] <= BASIS_W'(1) << FRAC_W;
				j_q <= DEG_W'(1);
				r_q <= '0;
				saved_q <= '0;
			end
			S_MUL: begin
				prod_q <= PROD_W'(b * rt);
				den_q <= rt + lt;
			end
			S_LOAD: begin
				// The quotient never exceeds b, so the top bits start below den.
				rem_q <= prod_q[PROD_W-1:BASIS_W];
				low_q <= prod_q[BASIS_W-1:0];
				cnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= ge ? XS_W'(trial - {1'b0, den_q}) : XS_W'(trial);
				low_q <= low_q << 1;
				quo_q <= {quo_q[BASIS_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			S_UPD: begin
				nb_q[r_q[NB_IDX_W-1:0]] <= saved_q + part;
				if (r_q == j_q - 1'b1) begin
					nb_q[j_q[NB_IDX_W-1:0]] <= b - part;
					j_q <= j_q + 1'b1;
					r_q <= '0;
					saved_q <= '0;
				end else begin
					r_q <= r_q + 1'b1;
					saved_q <= b - part;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign span = span_q;
	assign nb = nb_q;

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> cnt_q < DCNT_W'(DIV_STEPS))
		else $error("divider ran past its last step");
	a_part_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_UPD && den_q != '0) |-> quo_q <= b)
		else $error("basis split exceeds its parent value");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_MUL || st_q == S_DIV || st_q == S_UPD) |->
		(j_q != '0 && j_q <= deg_q && r_q < j_q))
		else $error("recurrence indices out of range");
endmodule

// ===== hw/rtl/bsb_mac.sv =====
// ----------------------------------------------------------------------------
// bsb_mac
// Tensor-product weighted sum of control points through one shared
// multiplier: row sums over u, then the sum of rows over v, per coordinate.
// ----------------------------------------------------------------------------
module bsb_mac #(
	parameter int MAX_ROWS   = bsb_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS   = bsb_pkg::DEF_MAX_COLS,
	parameter int MAX_DEGREE = bsb_pkg::DEF_MAX_DEGREE
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  bsb_pkg::bsb_mac_ctl_t                      ctl,
	input  logic [MAX_DEGREE:0][bsb_pkg::BASIS_W-1:0]  nu,
	input  logic [MAX_DEGREE:0][bsb_pkg::BASIS_W-1:0]  nv,
	output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]       raddr,
	input  logic [bsb_pkg::COORD_W-1:0]                rd_x,
	input  logic [bsb_pkg::COORD_W-1:0]                rd_y,
	input  logic [bsb_pkg::COORD_W-1:0]                rd_z,
	output logic                                       done,
	output logic [bsb_pkg::COORD_W-1:0]                res_x,
	output logic [bsb_pkg::COORD_W-1:0]                res_y,
	output logic [bsb_pkg::COORD_W-1:0]                res_z
);
	import bsb_pkg::*;

	localparam int NB_IDX_W = $clog2(MAX_DEGREE + 1);
	localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_ADDR = 3'd1;
	localparam logic [2:0] M_MUL  = 3'd2;
	localparam logic [2:0] M_ACC  = 3'd3;
	localparam logic [2:0] M_RMUL = 3'd4;
	localparam logic [2:0] M_RACC = 3'd5;

	logic [2:0]                st_q;
	logic [DEG_W-1:0]          k_q;
	logic [DEG_W-1:0]          l_q;
	logic [1:0]                c_q;
	logic signed [MPROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   rowsum_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [COORD_W-1:0]        res_q [3];
	logic                      done_q;

	logic [CNT_W-1:0]        row;
	logic [CNT_W-1:0]        col;
	logic [COORD_W-1:0]      coord;
	logic [COORD_W-1:0]      rowv;
	logic [BASIS_W-1:0]      mul_a;
	logic [COORD_W-1:0]      mul_b;
	logic signed [ACC_W-1:0] acc_next;

	always_comb begin
		row = ctl.span_u - CNT_W'(ctl.p) + CNT_W'(k_q);
		col = ctl.span_v - CNT_W'(ctl.q) + CNT_W'(l_q);
		raddr = ADDR_W'(row * MAX_COLS + col);
		case (c_q)
			2'd0: coord = rd_x;
			2'd1: coord = rd_y;
			default: coord = rd_z;
		endcase
		rowv = sat_floor(rowsum_q);
		if (st_q == M_MUL) begin
			mul_a = nu[k_q[NB_IDX_W-1:0]];
			mul_b = coord;
		end else begin
			mul_a = nv[l_q[NB_IDX_W-1:0]];
			mul_b = rowv;
		end
		acc_next = acc_q + ACC_W'(prod_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (start) begin
						st_q <= M_ADDR;
					end
				end
				M_ADDR: st_q <= M_MUL;
				M_MUL: st_q <= M_ACC;
				M_ACC: st_q <= (k_q == ctl.p) ? M_RMUL : M_ADDR;
				M_RMUL: st_q <= M_RACC;
				M_RACC: begin
					if (l_q == ctl.q && c_q == 2'd2) begin
						st_q <= M_IDLE;
						done_q <= 1'b1;
					end else begin
						st_q <= M_ADDR;
					end
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				k_q <= '0;
				l_q <= '0;
				c_q <= '0;
				rowsum_q <= '0;
				acc_q <= '0;
			end
			M_MUL, M_RMUL: prod_q <= $signed({1'b0, mul_a}) * $signed(mul_b);
			M_ACC: begin
				rowsum_q <= rowsum_q + ACC_W'(prod_q);
				if (k_q != ctl.p) begin
					k_q <= k_q + 1'b1;
				end
			end
			M_RACC: begin
				rowsum_q <= '0;
				k_q <= '0;
				if (l_q == ctl.q) begin
					res_q[c_q] <= sat_floor(acc_next);
					acc_q <= '0;
					l_q <= '0;
					c_q <= c_q + 1'b1;
				end else begin
					acc_q <= acc_next;
					l_q <= l_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res_x = res_q[0];
	assign res_y = res_q[1];
	assign res_z = res_q[2];
endmodule

// ===== bench/bspline_surface_point_eval_tb.sv =====
// ----------------------------------------------------------------------------
// bspline_surface_point_eval_tb
// Self-checking bench for the B-spline surface point evaluator: it fills the
// control grid, then runs directed and random load and evaluate words under
// several register settings and idle patterns, and checks every result word
// against a bit-exact fixed-point model of the surface evaluation.
// ----------------------------------------------------------------------------
module bspline_surface_point_eval_tb;
	import bsb_pkg::*;

	typedef struct {
		logic [1:0]         st;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} surf_word_t;

	class surface_scoreboard;
		logic signed [31:0] grid_x[256];
		logic signed [31:0] grid_y[256];
		logic signed [31:0] grid_z[256];
		int rows_reg, cols_reg, udeg_reg, vdeg_reg;
		surf_word_t pending_q[$];
		int mismatches;

		function new();
			rows_reg = int'(RST_ROWS);
			cols_reg = int'(RST_COLS);
			udeg_reg = int'(RST_UDEG);
			vdeg_reg = int'(RST_VDEG);
			mismatches = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [4:0] val);
			case (idx)
				CFG_ROWS: rows_reg = int'(val);
				CFG_COLS: cols_reg = int'(val);
				CFG_UDEG: udeg_reg = int'(val[2:0]);
				CFG_VDEG: vdeg_reg = int'(val[2:0]);
				default: ;
			endcase
		endfunction

		function longint knot_at(longint i, longint deg, longint dspan);
			longint k;
			k = i - deg;
			if (k < 0) k = 0;
			if (k > dspan) k = dspan;
			return k * ONE_Q16;
		endfunction

		// Span search and Q0.30 basis values; the values always sum to 2^30.
		function longint span_basis(longint n, longint deg, longint x, output longint nb[6]);
			longint dspan, xs, seg, span, saved, b, rt, dd, part;
			longint left[6];
			longint right[6];
			dspan = n - deg;
			xs = x * dspan;
			seg = xs / ONE_Q16;
			if (seg > dspan - 1) seg = dspan - 1;
			span = deg + seg;
			nb = '{default: 0};
			nb[0] = longint'(1) << 30;
			for (int j = 1; j <= deg; j++) begin
				saved = 0;
				left[j] = xs - knot_at(span + 1 - j, deg, dspan);
				right[j] = knot_at(span + j, deg, dspan) - xs;
				for (int r = 0; r < j; r++) begin
					b = nb[r];
					rt = right[r + 1];
					dd = rt + left[j - r];
					part = (dd != 0) ? (b * rt) / dd : 0;
					nb[r] = saved + part;
					saved = b - part;
				end
				nb[j] = saved;
			end
			return span;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'h7fffffff;
			if (v < -64'sd2147483648) return 32'h80000000;
			return v[31:0];
		endfunction

		function surf_word_t surface_point(int u, int v);
			surf_word_t w;
			longint nr, nc, p, q, su, sv, acc, rowsum, pt;
			longint nu[6];
			longint nv[6];
			int a;
			w = '{STAT_OK, 0, 0, 0};
			nr = (rows_reg > 16) ? 16 : rows_reg;
			nc = (cols_reg > 16) ? 16 : cols_reg;
			p = (udeg_reg > 5) ? 5 : udeg_reg;
			q = (vdeg_reg > 5) ? 5 : vdeg_reg;
			if (nr <= p || nc <= q) begin
				w.st = STAT_FEW;
				return w;
			end
			if (u > ONE_Q16 || v > ONE_Q16) begin
				w.st = STAT_RANGE;
				return w;
			end
			su = span_basis(nr, p, u, nu);
			sv = span_basis(nc, q, v, nv);
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int l = 0; l <= q; l++) begin
					rowsum = 0;
					for (int k = 0; k <= p; k++) begin
						a = int'((su - p + k) * 16 + (sv - q + l));
						pt = (c == 0) ? longint'(grid_x[a]) :
							(c == 1) ? longint'(grid_y[a]) : longint'(grid_z[a]);
						rowsum += nu[k] * pt;
					end
					acc += nv[l] * longint'(clamp32(rowsum >>> 30));
				end
				case (c)
					0: w.x = clamp32(acc >>> 30);
					1: w.y = clamp32(acc >>> 30);
					default: w.z = clamp32(acc >>> 30);
				endcase
			end
			return w;
		endfunction

		function void note_input(logic cmd, logic [3:0] ri, logic [3:0] ci,
				logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
				logic [16:0] u, logic [16:0] v);
			surf_word_t w;
			if (cmd == CMD_LOAD) begin
				grid_x[ri * 16 + ci] = px;
				grid_y[ri * 16 + ci] = py;
				grid_z[ri * 16 + ci] = pz;
				w = '{STAT_OK, 0, 0, 0};
			end else begin
				w = surface_point(u, v);
			end
			pending_q = {pending_q, w};
		endfunction

		function void check_result(logic [1:0] st, logic signed [31:0] x,
				logic signed [31:0] y, logic signed [31:0] z);
			surf_word_t e;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word: status %0d x %h y %h z %h", st, x, y, z);
				return;
			end
			e = pending_q.pop_front();
			if (st !== e.st || x !== e.x || y !== e.y || z !== e.z) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp st %0d x %h y %h z %h, got st %0d x %h y %h z %h",
						e.st, e.x, e.y, e.z, st, x, y, z);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic command = CMD_LOAD;
	logic [3:0] row_index = '0;
	logic [3:0] col_index = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_y = '0;
	logic signed [31:0] point_z = '0;
	logic [16:0] u_coord = '0;
	logic [16:0] v_coord = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [STAT_W-1:0] status;
	logic signed [31:0] out_x, out_y, out_z;

	surface_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_sent = 0;
	int shapes[9][4] = '{
		'{16, 16, 5, 5}, '{1, 1, 0, 0}, '{16, 16, 0, 0}, '{31, 31, 7, 7},
		'{3, 8, 3, 2}, '{0, 0, 0, 0}, '{6, 16, 5, 1}, '{2, 5, 1, 4},
		'{9, 7, 2, 6}
	};

	bspline_surface_point_eval dut (.*);

	always #6 clk = ~clk;

	// Result side: values read here are the ones present before the edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, out_x, out_y, out_z);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_word(logic cmd, logic [3:0] ri, logic [3:0] ci,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [16:0] u, logic [16:0] v);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		command <= cmd;
		row_index <= ri;
		col_index <= ci;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		u_coord <= u;
		v_coord <= v;
		do @(posedge clk); while (in_stall);
		sb.note_input(cmd, ri, ci, px, py, pz, u, v);
		words_sent++;
		if (words_sent < 184) begin
			send_idle_pct = 7;
			recv_stall_pct = 52;
		end else if (words_sent < 368) begin
			send_idle_pct = 52;
			recv_stall_pct = 7;
		end else begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h0003ffff) - 32'h00020000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [16:0] rand_param();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	task automatic send_load(logic [3:0] ri, logic [3:0] ci);
		send_word(CMD_LOAD, ri, ci, rand_coord(), rand_coord(), rand_coord(),
			17'($urandom), 17'($urandom));
	endtask

	task automatic send_eval(logic [16:0] u, logic [16:0] v);
		send_word(CMD_EVAL, 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom,
			u, v);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_shape(int rows, int cols, int udeg, int vdeg);
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(CFG_ROWS, 5'(rows));
		write_reg(CFG_COLS, 5'(cols));
		write_reg(CFG_UDEG, 5'(udeg));
		write_reg(CFG_VDEG, 5'(vdeg));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 7;
		recv_stall_pct = 52;

		// Every grid entry is written first so that no evaluation reads an
		// entry that was never loaded.
		for (int i = 0; i < 256; i++) send_load(4'(i / 16), 4'(i % 16));

		// Directed words under the reset shape: parameter ends, interior,
		// range errors on each side, extreme points at two grid corners and at entry (1,1).
		send_eval(17'd0, 17'd0);
		send_eval(17'd65536, 17'd65536);
		send_eval(17'd65536, 17'd0);
		send_eval(17'd0, 17'd65536);
		send_eval(17'd32768, 17'd12345);
		send_eval(17'd65537, 17'd100);
		send_eval(17'd100, 17'd131071);
		send_eval(17'd131071, 17'd131071);
		send_word(CMD_LOAD, 4'd0, 4'd0, 32'h7fffffff, 32'h80000000, 32'h0, 17'h1ffff, 17'h1ffff);
		send_word(CMD_LOAD, 4'd15, 4'd15, 32'h80000000, 32'h7fffffff, 32'hffffffff, 17'd0, 17'd0);
		send_word(CMD_LOAD, 4'd1, 4'd1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'd5, 17'd5);
		send_eval(17'd0, 17'd0);
		send_eval(17'd10000, 17'd10000);
		send_eval(17'd65535, 17'd1);

		// Too few points wins over a range error.
		set_shape(3, 4, 3, 3);
		send_eval(17'd70000, 17'd0);
		send_eval(17'd100, 17'd100);

		foreach (shapes[s]) begin
			set_shape(shapes[s][0], shapes[s][1], shapes[s][2], shapes[s][3]);
			for (int n = 0; n < 31; n++) begin
				if ($urandom_range(99) < 35) send_load(4'($urandom), 4'($urandom));
				else send_eval(rand_param(), rand_param());
			end
		end

		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("bspline_surface_point_eval verification clean");
		end else begin
			$display("bspline_surface_point_eval verification failed");
		end
		$finish;
	end

	initial begin
		#(12 * 8000000);
		$display("bspline_surface_point_eval verification failed");
		$finish;
	end

endmodule
